### hdl/gbd_pkg.sv
// ============================================================================
// gbd_pkg
// Shared types, constants and report helper for the gamepad button debouncer.
// ============================================================================
`default_nettype none

package gbd_pkg;

  // Default build: two pads of twelve buttons each.
  localparam int BUTTONS_PER_PAD_DEF = 12;
  localparam int PAD_COUNT_DEF       = 2;

  // Fixed field widths.
  localparam int RAW_W   = 12;
  localparam int COUNT_W = 8;
  localparam int AXIS_W  = 8;
  localparam int KEYS_W  = 8;
  localparam int MASK_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Count value that both registers and every counter take at reset.
  localparam logic [COUNT_W-1:0] RESET_COUNT = 8'd10;

  // Button positions inside one pad's raw word.
  localparam int BTN_UP        = 0;
  localparam int BTN_DOWN      = 1;
  localparam int BTN_LEFT      = 2;
  localparam int BTN_RIGHT     = 3;
  localparam int BTN_FIRST_KEY = 4;

  // Axis levels.
  localparam logic signed [AXIS_W-1:0] AXIS_POS  = 8'sd127;
  localparam logic signed [AXIS_W-1:0] AXIS_NEG  = -8'sd127;
  localparam logic signed [AXIS_W-1:0] AXIS_ZERO = 8'sd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELEASE_COUNT = 1'b0,
    REG_PRESS_COUNT   = 1'b1
  } cfg_reg_t;

  // One input item.
  typedef struct packed {
    logic [RAW_W-1:0] pad1_raw;
    logic [RAW_W-1:0] pad2_raw;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [AXIS_W-1:0] pad1_x;
    logic signed [AXIS_W-1:0] pad1_y;
    logic        [KEYS_W-1:0] pad1_buttons;
    logic signed [AXIS_W-1:0] pad2_x;
    logic signed [AXIS_W-1:0] pad2_y;
    logic        [KEYS_W-1:0] pad2_buttons;
    logic        [MASK_W-1:0] changed_mask;
  } out_t;

  // One stored button: debounced level and its down-counter.
  typedef struct packed {
    logic               held;
    logic [COUNT_W-1:0] ticks;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{held: 1'b0, ticks: RESET_COUNT};

  // Axis and key report of one pad.
  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic        [KEYS_W-1:0] keys;
  } pad_rpt_t;

  // Builds a pad report from its held bits; right beats left, down beats up.
  function automatic pad_rpt_t pad_report(input logic [RAW_W-1:0] held);
    pad_rpt_t r;
    if (held[BTN_RIGHT]) begin
      r.x = AXIS_POS;
    end else if (held[BTN_LEFT]) begin
      r.x = AXIS_NEG;
    end else begin
      r.x = AXIS_ZERO;
    end
    if (held[BTN_DOWN]) begin
      r.y = AXIS_NEG;
    end else if (held[BTN_UP]) begin
      r.y = AXIS_POS;
    end else begin
      r.y = AXIS_ZERO;
    end
    r.keys = held[RAW_W-1:BTN_FIRST_KEY];
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/gbd_state_ram.sv
// ============================================================================
// gbd_state_ram
// Button state memory with one read and one write port, registered read
// data, and per-entry valid bits so that unwritten entries read as reset.
// ============================================================================
`default_nettype none

module gbd_state_ram #(
  parameter int DEPTH  = gbd_pkg::BUTTONS_PER_PAD_DEF * gbd_pkg::PAD_COUNT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output gbd_pkg::entry_t          rd_data,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire gbd_pkg::entry_t     wr_data
);

  gbd_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  gbd_pkg::entry_t  rdata_r;
  logic             rvalid_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Valid bits: cleared at reset, set by the first write of each entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never written reads as a released button with a full count.
  assign rd_data = rvalid_r ? rdata_r : gbd_pkg::RESET_ENTRY;

endmodule

`default_nettype wire

### hdl/gamepad_button_debouncer.sv
// ============================================================================
// gamepad_button_debouncer
// Asymmetric counter debouncer for up to two gamepads with joystick reports.
// ============================================================================
// Usage: each transfer on the in_ channel is one tick carrying the active-low
// raw levels of every button. Each tick yields exactly one transfer on the
// out_ channel with both pads' axes, button bytes and a per-pad changed mask.
// The button states and counters live in one memory with registered read
// data. A sequencer visits one button per cycle while the sweep is not held:
// read, then update and write back in the write-back stage. A tick occupies
// the sweep for PAD_COUNT * BUTTONS_PER_PAD buttons (24 by default), and the
// next tick is taken in the cycle the last button is read, so ticks stream
// back to back. The result sits in an output register; while it waits, the
// next tick is accepted and swept, and the sweep holds at the final
// write-back of that tick if the register is still full. At reset all
// buttons are released, all counters and both count registers are 10;
// there is no clearing pass. Configuration writes on cfg_ take effect at
// the next counter reload.
// ============================================================================
`default_nettype none

module gamepad_button_debouncer #(
  parameter int BUTTONS_PER_PAD = gbd_pkg::BUTTONS_PER_PAD_DEF,
  parameter int PAD_COUNT       = gbd_pkg::PAD_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire gbd_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output gbd_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [gbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbd_pkg::COUNT_W-1:0]    cfg_wdata
);

  localparam int DEPTH  = BUTTONS_PER_PAD * PAD_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BTN_W  = $clog2(BUTTONS_PER_PAD);
  localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(BUTTONS_PER_PAD - 1);
  localparam logic             LAST_PAD = 1'(PAD_COUNT - 1);

  // Count registers.
  logic [gbd_pkg::COUNT_W-1:0] release_count_r;
  logic [gbd_pkg::COUNT_W-1:0] press_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_count_r <= gbd_pkg::RESET_COUNT;
      press_count_r   <= gbd_pkg::RESET_COUNT;
    end else if (cfg_we) begin
      unique case (gbd_pkg::cfg_reg_t'(cfg_index))
        gbd_pkg::REG_RELEASE_COUNT: release_count_r <= cfg_wdata;
        gbd_pkg::REG_PRESS_COUNT:   press_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic              advance;
  logic              rd_active_r;
  logic              rd_pad_r;
  logic [BTN_W-1:0]  rd_btn_r;
  logic              rd_last;
  logic [BUTTONS_PER_PAD-1:0] raw1_r;
  logic [BUTTONS_PER_PAD-1:0] raw2_r;
  logic [ADDR_W-1:0] rd_addr;

  logic              wb_active_r;
  logic              wb_pad_r;
  logic [BTN_W-1:0]  wb_btn_r;
  logic              wb_last_r;
  logic              wb_raw_r;
  logic [ADDR_W-1:0] wb_addr;

  logic              out_valid_r;
  gbd_pkg::out_t     out_data_r;

  logic              accept;

  // The sweep holds only when a finished tick meets a full output register.
  assign advance  = !(wb_active_r && wb_last_r && out_valid_r && !out_ready);
  assign rd_last  = (rd_btn_r == LAST_BTN) && (rd_pad_r == LAST_PAD);
  assign in_ready = advance && (!rd_active_r || rd_last);
  assign accept   = in_valid && in_ready;

  assign rd_addr = rd_pad_r ? (ADDR_W'(BUTTONS_PER_PAD) + ADDR_W'(rd_btn_r))
                            : ADDR_W'(rd_btn_r);
  assign wb_addr = wb_pad_r ? (ADDR_W'(BUTTONS_PER_PAD) + ADDR_W'(wb_btn_r))
                            : ADDR_W'(wb_btn_r);

  // Read stage: steps through every button of every pad.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_active_r <= 1'b0;
      rd_pad_r    <= 1'b0;
      rd_btn_r    <= '0;
    end else if (accept) begin
      rd_active_r <= 1'b1;
      rd_pad_r    <= 1'b0;
      rd_btn_r    <= '0;
    end else if (advance && rd_active_r) begin
      if (rd_last) begin
        rd_active_r <= 1'b0;
      end else if (rd_btn_r == LAST_BTN) begin
        rd_pad_r <= 1'b1;
        rd_btn_r <= '0;
      end else begin
        rd_btn_r <= rd_btn_r + 1'b1;
      end
    end
  end

  // Raw levels of the tick in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      raw1_r <= in_data.pad1_raw[BUTTONS_PER_PAD-1:0];
      raw2_r <= in_data.pad2_raw[BUTTONS_PER_PAD-1:0];
    end
  end

  // Write-back stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_active_r <= 1'b0;
    end else if (advance) begin
      wb_active_r <= rd_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wb_pad_r  <= rd_pad_r;
      wb_btn_r  <= rd_btn_r;
      wb_last_r <= rd_last;
      wb_raw_r  <= rd_pad_r ? raw2_r[rd_btn_r] : raw1_r[rd_btn_r];
    end
  end

  // State memory.
  gbd_pkg::entry_t rd_entry;
  gbd_pkg::entry_t wr_entry;
  logic            wr_en;

  assign wr_en = wb_active_r && advance;

  gbd_state_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_state_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_active_r && advance),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wb_addr),
    .wr_data (wr_entry)
  );

  // Debounce update of the button in the write-back stage.
  logic                        now_held;
  logic [gbd_pkg::COUNT_W-1:0] dec_ticks;
  logic                        flip;

  always_comb begin
    now_held  = !wb_raw_r;
    dec_ticks = rd_entry.ticks - 1'b1;
    flip      = 1'b0;
    wr_entry  = rd_entry;
    if (now_held == rd_entry.held) begin
      wr_entry.ticks = rd_entry.held ? release_count_r : press_count_r;
    end else if (dec_ticks == '0) begin
      flip           = 1'b1;
      wr_entry.held  = now_held;
      wr_entry.ticks = now_held ? release_count_r : press_count_r;
    end else begin
      wr_entry.ticks = dec_ticks;
    end
  end

  // Collect the updated held bits and changed flags over the sweep.
  logic [BUTTONS_PER_PAD-1:0] held1_r;
  logic [BUTTONS_PER_PAD-1:0] held2_r;
  logic                       chg1_r;
  logic                       chg2_r;
  logic [BUTTONS_PER_PAD-1:0] held1_fin;
  logic [BUTTONS_PER_PAD-1:0] held2_fin;
  logic                       chg1_fin;
  logic                       chg2_fin;

  always_comb begin
    held1_fin = held1_r;
    held2_fin = held2_r;
    if (wb_pad_r) begin
      held2_fin[wb_btn_r] = wr_entry.held;
    end else begin
      held1_fin[wb_btn_r] = wr_entry.held;
    end
    chg1_fin = chg1_r || (flip && !wb_pad_r);
    chg2_fin = chg2_r || (flip && wb_pad_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held1_r <= held1_fin;
      held2_r <= held2_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg1_r <= 1'b0;
      chg2_r <= 1'b0;
    end else if (wr_en) begin
      chg1_r <= wb_last_r ? 1'b0 : chg1_fin;
      chg2_r <= wb_last_r ? 1'b0 : chg2_fin;
    end
  end

  // Report of the finished tick.
  gbd_pkg::pad_rpt_t rpt1;
  gbd_pkg::pad_rpt_t rpt2;
  gbd_pkg::out_t     result;

  always_comb begin
    rpt1 = gbd_pkg::pad_report(gbd_pkg::RAW_W'(held1_fin));
    rpt2 = gbd_pkg::pad_report(gbd_pkg::RAW_W'(held2_fin));
    result.pad1_x       = rpt1.x;
    result.pad1_y       = rpt1.y;
    result.pad1_buttons = rpt1.keys;
    if (PAD_COUNT >= 2) begin
      result.pad2_x       = rpt2.x;
      result.pad2_y       = rpt2.y;
      result.pad2_buttons = rpt2.keys;
      result.changed_mask = {chg2_fin, chg1_fin};
    end else begin
      result.pad2_x       = gbd_pkg::AXIS_ZERO;
      result.pad2_y       = gbd_pkg::AXIS_ZERO;
      result.pad2_buttons = '0;
      result.changed_mask = {1'b0, chg1_fin};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_en && wb_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wb_last_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished tick always lands in the output register.
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_active_r && wb_last_r && advance) |=> out_valid_r)
    else $error("finished tick did not reach the output register");

  // Read and write-back never touch the same entry in one cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_active_r && rd_active_r) |-> (wb_addr != rd_addr))
    else $error("read and write-back address the same entry");

  // A result appears only after the last button of a tick is written.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(wb_active_r && wb_last_r))
    else $error("result raised without a finished tick");

  // With nonzero count registers no counter is ever stored as zero.
  a_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (release_count_r != '0) && (press_count_r != '0))
      |-> (wr_entry.ticks != '0))
    else $error("counter written as zero");

endmodule

`default_nettype wire
